/* design/bsw_pkg.sv */
package bsw_pkg;

  localparam int PC_W  = 3;
  localparam int CNT_W = 6;
  localparam int WORD_W = 32;
  localparam int IDX_W = 5;

  // Datapath operation selected by the control word
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_MUL,
    OP_DIV,
    OP_NEXT,
    OP_WEIGHT,
    OP_EMIT
  } op_t;

  // Jump condition selected by the control word
  typedef enum logic [2:0] {
    C_NONE,
    C_ALWAYS,
    C_NO_REQ,
    C_K_DONE,
    C_DIV_MORE,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  // Status flags fed back from datapath to sequencer
  typedef struct packed {
    logic k_done;
    logic div_more;
  } status_t;

  localparam logic [PC_W-1:0] ST_LOAD   = 3'd0;
  localparam logic [PC_W-1:0] ST_CHECK  = 3'd1;
  localparam logic [PC_W-1:0] ST_MUL    = 3'd2;
  localparam logic [PC_W-1:0] ST_DIV    = 3'd3;
  localparam logic [PC_W-1:0] ST_NEXT   = 3'd4;
  localparam logic [PC_W-1:0] ST_WEIGHT = 3'd5;
  localparam logic [PC_W-1:0] ST_EMIT   = 3'd6;
  localparam logic [PC_W-1:0] ST_RET    = 3'd7;

  // Control store: one word per step
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      ST_LOAD:   w = '{op: OP_LOAD,   cond: C_NO_REQ,   target: ST_LOAD};
      ST_CHECK:  w = '{op: OP_NOP,    cond: C_K_DONE,   target: ST_WEIGHT};
      ST_MUL:    w = '{op: OP_MUL,    cond: C_NONE,     target: ST_LOAD};
      ST_DIV:    w = '{op: OP_DIV,    cond: C_DIV_MORE, target: ST_DIV};
      ST_NEXT:   w = '{op: OP_NEXT,   cond: C_ALWAYS,   target: ST_CHECK};
      ST_WEIGHT: w = '{op: OP_WEIGHT, cond: C_NONE,     target: ST_LOAD};
      ST_EMIT:   w = '{op: OP_EMIT,   cond: C_OUT_BUSY, target: ST_EMIT};
      ST_RET:    w = '{op: OP_NOP,    cond: C_ALWAYS,   target: ST_LOAD};
      default:   w = '{op: OP_NOP,    cond: C_ALWAYS,   target: ST_LOAD};
    endcase
    return w;
  endfunction

endpackage

/* design/bsw_dp.sv */
module bsw_dp
  import bsw_pkg::*;
(
  input  logic              clk,
  input  op_t               op,
  input  logic              load_en,
  input  logic [CNT_W-1:0]  feature_count,
  input  logic [CNT_W-1:0]  subset_size,
  output status_t           status,
  output logic [WORD_W-1:0] coef,
  output logic [WORD_W-1:0] wt,
  output logic              err
);

  logic [CNT_W-1:0]  n;
  logic [CNT_W-1:0]  s;
  logic [IDX_W-1:0]  k;
  logic [IDX_W-1:0]  i;
  logic [WORD_W-1:0] acc;
  logic [WORD_W-1:0] quo;
  logic [IDX_W-1:0]  rem;
  logic [IDX_W-1:0]  dcnt;
  logic [WORD_W-1:0] wt_r;
  logic              err_r;

  logic [CNT_W-1:0]        diff_in;
  logic [CNT_W-1:0]        kmin_in;
  logic [CNT_W-1:0]        mul_op;
  logic [WORD_W+CNT_W-1:0] prod;
  logic [IDX_W:0]          rem_sh;
  logic [IDX_W:0]          dvs;
  logic                    q_bit;

  // k = min(s, n-s) for the incoming request
  always_comb begin
    diff_in = feature_count - subset_size;
    kmin_in = (subset_size < diff_in) ? subset_size : diff_in;
  end

  // Shared multiplier: acc times (n-i) or (n-s)
  always_comb begin
    if (op == OP_WEIGHT) begin
      mul_op = n - s;
    end else begin
      mul_op = n - {1'b0, i};
    end
    prod = {{CNT_W{1'b0}}, acc} * {{WORD_W{1'b0}}, mul_op};
  end

  // One restoring division step, divisor is i+1
  always_comb begin
    dvs    = {1'b0, i} + (IDX_W+1)'(1);
    rem_sh = {rem, quo[WORD_W-1]};
    q_bit  = (rem_sh >= dvs);
  end

  always_ff @(posedge clk) begin
    unique case (op)
      OP_LOAD: begin
        if (load_en) begin
          n     <= feature_count;
          s     <= subset_size;
          err_r <= (subset_size > feature_count);
          k     <= (subset_size > feature_count) ? '0 : kmin_in[IDX_W-1:0];
          acc   <= WORD_W'(1);
          i     <= '0;
        end
      end
      OP_MUL: begin
        quo  <= prod[WORD_W-1:0];
        rem  <= '0;
        dcnt <= '1;
      end
      OP_DIV: begin
        if (q_bit) begin
          rem <= IDX_W'(rem_sh - dvs);
        end else begin
          rem <= rem_sh[IDX_W-1:0];
        end
        quo  <= {quo[WORD_W-2:0], q_bit};
        dcnt <= dcnt - IDX_W'(1);
      end
      OP_NEXT: begin
        acc <= quo;
        i   <= i + IDX_W'(1);
      end
      OP_WEIGHT: begin
        wt_r <= prod[WORD_W-1:0];
      end
      OP_NOP, OP_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  assign status.k_done   = (i == k);
  assign status.div_more = (dcnt != '0);
  assign err  = err_r;
  assign coef = err_r ? '0 : acc;
  assign wt   = err_r ? '0 : wt_r;

endmodule

/* design/binomial_shapley_weight.sv */
// Channel   Handshake              Payload
// request   req_valid/req_ready    feature_count[5:0], subset_size[5:0]
// result    rsp_valid/rsp_ready    binomial[31:0], weight[31:0], range_error
//
// One request at a time: a load step, then k = min(s, n-s) loop passes
// (check, multiply, bit-serial divide, update), then final check, weight,
// emit and return. Reset returns the sequencer to the load step and clears
// rsp_valid; the result data registers are not reset. A result held by
// rsp_ready low stalls the sequencer at the emit step; the next request is
// taken after it.
module binomial_shapley_weight
  import bsw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic [CNT_W-1:0]  feature_count,
  input  logic [CNT_W-1:0]  subset_size,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output logic [WORD_W-1:0] binomial,
  output logic [WORD_W-1:0] weight,
  output logic              range_error
);

  logic [PC_W-1:0]   pc;
  logic [PC_W-1:0]   pc_next;
  ucode_t            ctl;
  status_t           status;
  logic              accept;
  logic              out_busy;
  logic              taken;
  logic [WORD_W-1:0] coef;
  logic [WORD_W-1:0] wt;
  logic              err;

  assign ctl       = ucode_rom(pc);
  assign req_ready = !rst && (ctl.op == OP_LOAD);
  assign accept    = req_valid && req_ready;
  assign out_busy  = rsp_valid && !rsp_ready;

  // Evaluate jump condition and advance step counter
  always_comb begin
    unique case (ctl.cond)
      C_NONE:     taken = 1'b0;
      C_ALWAYS:   taken = 1'b1;
      C_NO_REQ:   taken = !req_valid;
      C_K_DONE:   taken = status.k_done;
      C_DIV_MORE: taken = status.div_more;
      C_OUT_BUSY: taken = out_busy;
      default:    taken = 1'b1;
    endcase
    pc_next = taken ? ctl.target : pc + PC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ST_LOAD;
    end else begin
      pc <= pc_next;
    end
  end

  bsw_dp u_dp (
    .clk           (clk),
    .op            (ctl.op),
    .load_en       (accept),
    .feature_count (feature_count),
    .subset_size   (subset_size),
    .status        (status),
    .coef          (coef),
    .wt            (wt),
    .err           (err)
  );

  // Hold result until taken; load on emit step when free
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.op == OP_EMIT && !out_busy) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == OP_EMIT && !out_busy) begin
      binomial    <= coef;
      weight      <= wt;
      range_error <= err;
    end
  end

endmodule
